FILE: sv/polyphase_fir_resampler_core_defines.svh
// Assertion macros for the resampler core.
`ifndef POLYPHASE_FIR_RESAMPLER_CORE_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PFR_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("pfr assertion failed");
`define PFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("pfr assertion failed");
`else
`define PFR_ASSERT(lbl, clk_s, rstn_s, prop)
`define PFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: sv/pfr_pkg.sv
// Shared constants, controller state type and control/status structs.
package pfr_pkg;

    localparam int TAPS_DEF       = 32;
    localparam int PHASES_DEF     = 256;
    localparam int RING_DEPTH_DEF = 64;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 18;
    localparam int COEF_ADDR_W = 13;
    localparam int COEF_DEPTH  = 1 << COEF_ADDR_W;
    localparam int COUNT_W     = 40;
    localparam int FRAC_W      = 24;
    localparam int POS_W       = COUNT_W + FRAC_W;
    localparam int STEP_W      = 29;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STEP_W;

    localparam int OUT_CAP   = 6;
    localparam int OUT_CNT_W = 3;

    localparam int MOD_BITS_PER_CYCLE = 4;
    localparam int MOD_CYCLES         = COUNT_W / MOD_BITS_PER_CYCLE;
    localparam int DRAIN_CYCLES       = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_W);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MODE = CFG_IDX_W'(1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIRECT,
        S_CHECK,
        S_EMIT,
        S_LOAD,
        S_MOD,
        S_INIT,
        S_FIR,
        S_DRAIN,
        S_DONE
    } pfr_state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mod_step;
        logic fir_init;
        logic issue;
        logic finish;
        logic emit;
        logic emit_direct;
        logic emit_last;
    } pfr_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic item_coef;
        logic direct;
        logic due;
        logic out_free;
    } pfr_sts_t;

endpackage

FILE: sv/pfr_if.sv
// Channel interfaces: input items, result words and configuration writes.
interface pfr_item_if import pfr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [COEF_ADDR_W-1:0]     coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, opcode, left_sample, right_sample, coef_index, coef_value,
                    input ready);
    modport sink (input valid, opcode, left_sample, right_sample, coef_index, coef_value,
                  output ready);
endinterface

interface pfr_result_if import pfr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last;

    modport source (output valid, out_left, out_right, last, input ready);
    modport sink (input valid, out_left, out_right, last, output ready);
endinterface

interface pfr_cfg_if import pfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pfr_datapath.sv
// Datapath: config registers, ring and coefficient memories, position, modulo unit, MAC.
module pfr_datapath import pfr_pkg::*; #(
    parameter int TAPS       = TAPS_DEF,
    parameter int PHASES     = PHASES_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pfr_cfg_if.sink           cfg,
    pfr_item_if.sink          item,
    pfr_result_if.source      result,
    input  pfr_cmd_t          cmd,
    output pfr_sts_t          sts
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int PH_W   = $clog2(PHASES);
    localparam int TAPS_W = $clog2(TAPS) + 1;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int SUM_W  = ACC_W - 16;

    localparam logic [COUNT_W-1:0] TAP_BACK  = COUNT_W'(TAPS / 2 - 1);
    localparam logic [POS_W-1:0]   HALF      = POS_W'(TAPS / 2) << FRAC_W;
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [SLOT_W:0]    DEPTH_X   = (SLOT_W + 1)'(RING_DEPTH);
    localparam logic [PH_W:0]      PHASES_X  = (PH_W + 1)'(PHASES);
    localparam logic [TAPS_W-1:0]  TAPS_X    = TAPS_W'(TAPS);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (SAMPLE_W - 1)));

    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        logic signed [SUM_W-1:0] q;
        logic [SAMPLE_W-1:0]     res;
        r = a + ACC_W'(32'sd32768);
        q = r[ACC_W-1:16];
        if (q > SAT_HI)
            res = SAT_HI[SAMPLE_W-1:0];
        else if (q < SAT_LO)
            res = SAT_LO[SAMPLE_W-1:0];
        else
            res = q[SAMPLE_W-1:0];
        return res;
    endfunction

    // configuration
    logic [STEP_W-1:0] step_reg;
    logic              direct_reg;

    // memories
    logic signed [SAMPLE_W-1:0] left_mem  [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] right_mem [RING_DEPTH];
    logic signed [COEF_W-1:0]   coef_mem  [COEF_DEPTH];
    logic [RING_DEPTH-1:0]      ring_vld_reg;

    // counters and position
    logic [COUNT_W-1:0] host_cnt_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [SLOT_W-1:0]  wr_slot_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_half_reg;

    // phase and addresses
    logic [FRAC_W+PH_W:0]     phase_prod;
    logic [PH_W-1:0]          phase_reg;
    logic [PH_W+TAPS_W-1:0]   cbase_prod;
    logic [COEF_ADDR_W-1:0]   coef_base_reg;
    logic [COUNT_W-1:0]       n0;
    logic [COUNT_W-1:0]       mod_sh_reg;
    logic [SLOT_W-1:0]        mod_r_reg;
    logic [SLOT_W-1:0]        mod_r_next;
    logic [SLOT_W:0]          mod_acc;
    logic [COUNT_W-1:0]       tap_num_reg;
    logic [SLOT_W-1:0]        rd_slot_reg;
    logic [SLOT_W-1:0]        rd_slot_next;
    logic [COEF_ADDR_W-1:0]   rd_coef_reg;

    // MAC pipeline
    logic signed [SAMPLE_W-1:0] l_q_reg;
    logic signed [SAMPLE_W-1:0] r_q_reg;
    logic                       vld_q_reg;
    logic signed [COEF_W-1:0]   coef_q_reg;
    logic signed [SAMPLE_W-1:0] l_in;
    logic signed [SAMPLE_W-1:0] r_in;
    logic signed [PROD_W-1:0]   prod_l_next;
    logic signed [PROD_W-1:0]   prod_r_next;
    logic signed [PROD_W-1:0]   prod_l_reg;
    logic signed [PROD_W-1:0]   prod_r_reg;
    logic signed [ACC_W-1:0]    acc_l_reg;
    logic signed [ACC_W-1:0]    acc_r_reg;
    logic                       s1_reg;
    logic                       s2_reg;

    // held sample, pending result, output register
    logic signed [SAMPLE_W-1:0] smp_l_reg;
    logic signed [SAMPLE_W-1:0] smp_r_reg;
    logic [SAMPLE_W-1:0]        pend_l_reg;
    logic [SAMPLE_W-1:0]        pend_r_reg;
    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg;
    logic signed [SAMPLE_W-1:0] out_r_reg;
    logic                       out_last_reg;

    logic item_acc;
    logic smp_acc;
    logic coef_acc;

    assign cfg.ready  = 1'b1;
    assign item.ready = cmd.in_ready;
    assign item_acc   = item.valid && cmd.in_ready;
    assign smp_acc    = item_acc && (item.opcode == OP_SAMPLE);
    assign coef_acc   = item_acc && (item.opcode == OP_COEF);

    assign sts.item_valid = item.valid;
    assign sts.item_coef  = (item.opcode == OP_COEF);
    assign sts.direct     = direct_reg;
    assign sts.due        = (pos_half_reg <= {idx_reg, FRAC_W'(0)});
    assign sts.out_free   = !out_vld_reg || result.ready;

    assign result.valid     = out_vld_reg;
    assign result.out_left  = out_l_reg;
    assign result.out_right = out_r_reg;
    assign result.last      = out_last_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg   <= STEP_RESET;
            direct_reg <= 1'b0;
        end else if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                CFG_STEP_RATIO:  step_reg   <= cfg.data[STEP_W-1:0];
                CFG_DIRECT_MODE: direct_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // host sample count, ring write slot, position
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            host_cnt_reg <= '0;
            idx_reg      <= '0;
            wr_slot_reg  <= '0;
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            pos_half_reg <= HALF;
        end else begin
            if (smp_acc) begin
                idx_reg                   <= host_cnt_reg;
                host_cnt_reg              <= host_cnt_reg + 1'b1;
                ring_vld_reg[wr_slot_reg] <= 1'b1;
                // slot follows count mod depth, including the 2^40 wrap
                if (host_cnt_reg == {COUNT_W{1'b1}} || wr_slot_reg == SLOT_LAST)
                    wr_slot_reg <= '0;
                else
                    wr_slot_reg <= wr_slot_reg + 1'b1;
            end
            if (cmd.finish) begin
                pos_reg      <= pos_reg + POS_W'(step_reg);
                pos_half_reg <= pos_half_reg + POS_W'(step_reg);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (smp_acc) begin
            left_mem[wr_slot_reg]  <= item.left_sample;
            right_mem[wr_slot_reg] <= item.right_sample;
            smp_l_reg              <= item.left_sample;
            smp_r_reg              <= item.right_sample;
        end
        if (cmd.issue) begin
            l_q_reg   <= left_mem[rd_slot_reg];
            r_q_reg   <= right_mem[rd_slot_reg];
            vld_q_reg <= ring_vld_reg[rd_slot_reg];
        end
    end

    always_ff @(posedge clk) begin
        if (coef_acc)
            coef_mem[item.coef_index] <= item.coef_value;
        if (cmd.issue)
            coef_q_reg <= coef_mem[rd_coef_reg];
    end

    // phase from fraction, then coefficient row base
    assign phase_prod = (FRAC_W + PH_W + 1)'(pos_reg[FRAC_W-1:0]) * (FRAC_W + PH_W + 1)'(PHASES_X);
    assign cbase_prod = (PH_W + TAPS_W)'(phase_reg) * (PH_W + TAPS_W)'(TAPS_X);

    always_ff @(posedge clk) begin
        phase_reg     <= phase_prod[FRAC_W+PH_W-1:FRAC_W];
        coef_base_reg <= COEF_ADDR_W'(cbase_prod);
    end

    // start sample number mod ring depth, MSB first, four bits per cycle
    assign n0 = pos_reg[POS_W-1:FRAC_W] - TAP_BACK;

    always_comb begin
        mod_acc = {1'b0, mod_r_reg};
        for (int i = 0; i < MOD_BITS_PER_CYCLE; i++) begin
            mod_acc = {mod_acc[SLOT_W-1:0], mod_sh_reg[COUNT_W-1-i]};
            if (mod_acc >= DEPTH_X)
                mod_acc = mod_acc - DEPTH_X;
        end
        mod_r_next = mod_acc[SLOT_W-1:0];
    end

    always_comb begin
        if (tap_num_reg == {COUNT_W{1'b1}} || rd_slot_reg == SLOT_LAST)
            rd_slot_next = '0;
        else
            rd_slot_next = rd_slot_reg + 1'b1;
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            mod_sh_reg  <= n0;
            mod_r_reg   <= '0;
            tap_num_reg <= n0;
        end else if (cmd.mod_step) begin
            mod_sh_reg <= mod_sh_reg << MOD_BITS_PER_CYCLE;
            mod_r_reg  <= mod_r_next;
        end else if (cmd.fir_init) begin
            rd_slot_reg <= mod_r_reg;
            rd_coef_reg <= coef_base_reg;
        end else if (cmd.issue) begin
            rd_slot_reg <= rd_slot_next;
            tap_num_reg <= tap_num_reg + 1'b1;
            rd_coef_reg <= rd_coef_reg + 1'b1;
        end
    end

    // multiply-accumulate
    assign l_in        = vld_q_reg ? l_q_reg : '0;
    assign r_in        = vld_q_reg ? r_q_reg : '0;
    assign prod_l_next = l_in * coef_q_reg;
    assign prod_r_next = r_in * coef_q_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= cmd.issue;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_reg) begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
        if (cmd.load) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (s2_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
        if (cmd.finish) begin
            pend_l_reg <= round_sat(acc_l_reg);
            pend_r_reg <= round_sat(acc_r_reg);
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.emit)
            out_vld_reg <= 1'b1;
        else if (result.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (cmd.emit) begin
            out_l_reg    <= cmd.emit_direct ? smp_l_reg : $signed(pend_l_reg);
            out_r_reg    <= cmd.emit_direct ? smp_r_reg : $signed(pend_r_reg);
            out_last_reg <= cmd.emit_last;
        end
    end

endmodule

FILE: sv/pfr_ctrl.sv
// Controller: sequences output checks, modulo setup, tap loop and word emission.
`include "polyphase_fir_resampler_core_defines.svh"

module pfr_ctrl import pfr_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  pfr_sts_t sts,
    output pfr_cmd_t cmd
);

    localparam int CNT_MAX = (TAPS > MOD_CYCLES) ? TAPS : MOD_CYCLES;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam logic [CNT_W-1:0]     TAPS_LAST  = CNT_W'(TAPS - 1);
    localparam logic [CNT_W-1:0]     MOD_LAST   = CNT_W'(MOD_CYCLES - 1);
    localparam logic [CNT_W-1:0]     DRAIN_LAST = CNT_W'(DRAIN_CYCLES - 1);
    localparam logic [OUT_CNT_W-1:0] CAP        = OUT_CNT_W'(OUT_CAP);

    pfr_state_t           state_reg;
    pfr_state_t           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [OUT_CNT_W-1:0] k_reg;
    logic [OUT_CNT_W-1:0] k_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic                 due_reg;
    logic                 due_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            due_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
            due_reg   <= due_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        due_next   = due_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (sts.item_valid && !sts.item_coef) begin
                    k_next     = '0;
                    pend_next  = 1'b0;
                    state_next = sts.direct ? S_DIRECT : S_CHECK;
                end
            end
            S_DIRECT: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_direct = 1'b1;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_CHECK: begin
                // a finished word waits until we know whether another follows
                due_next = sts.due && (k_reg < CAP);
                if (pend_reg)
                    state_next = S_EMIT;
                else if (due_next)
                    state_next = S_LOAD;
                else
                    state_next = S_IDLE;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = !due_reg;
                    pend_next     = 1'b0;
                    state_next    = due_reg ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = S_MOD;
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == MOD_LAST) begin
                    cnt_next   = '0;
                    state_next = S_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_INIT: begin
                cmd.fir_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_FIR;
            end
            S_FIR: begin
                cmd.issue = 1'b1;
                if (cnt_reg == TAPS_LAST) begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (cnt_reg == DRAIN_LAST) begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                k_next     = k_reg + 1'b1;
                pend_next  = 1'b1;
                state_next = S_CHECK;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `PFR_ASSERT(a_out_cap, clk, rst_n, k_reg <= CAP)
    `PFR_ASSERT_NEXT(a_done_check, clk, rst_n, cmd.finish, (state_reg == S_CHECK) && pend_reg)
    `PFR_ASSERT_NEXT(a_load_mod, clk, rst_n, cmd.load, cmd.mod_step && (cnt_reg == '0))
    `PFR_ASSERT_NEXT(a_emit_hold, clk, rst_n, (state_reg == S_EMIT) && !sts.out_free, state_reg == S_EMIT)

endmodule

FILE: sv/polyphase_fir_resampler_core.sv
// Coefficient writes go into the coefficient store as the item is taken. In direct mode the held
// sample is registered as the output word from S_DIRECT, which waits there while the output is full.
// Per word: load, modulo setup, init, tap loop, MAC drain, then finish, check and emit.
// A sample gives k words (k up to 6); no new item is taken until all of them are emitted, plus stalls.
// Reset (async, low): config, counters, position and ring valid bits take their reset values at once.
// Coefficient store is not cleared; the ring needs no clearing pass.
module polyphase_fir_resampler_core import pfr_pkg::*; #(
    parameter int TAPS       = TAPS_DEF,
    parameter int PHASES     = PHASES_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pfr_cfg_if.sink      cfg,
    pfr_item_if.sink     item,
    pfr_result_if.source result
);

    pfr_cmd_t cmd;
    pfr_sts_t sts;

    pfr_datapath #(
        .TAPS       (TAPS),
        .PHASES     (PHASES),
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .sts    (sts)
    );

    pfr_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

endmodule

FILE: tb/polyphase_fir_resampler_core_test.sv
// Self-checking bench for the resampler core: coefficient load, directed and random traffic.
module polyphase_fir_resampler_core_test import pfr_pkg::*; ();

    localparam int PERIOD     = 20;
    localparam int TAPS       = TAPS_DEF;
    localparam int PHASES     = PHASES_DEF;
    localparam int RING_DEPTH = RING_DEPTH_DEF;
    localparam int DRAIN_WAIT = OUT_CAP * (TAPS + 18) + 100;

    // steps are whole quarters of a host sample, so only four coefficient rows are ever used
    localparam int QUARTER    = 1 << (FRAC_W - 2);
    localparam int STEP_Q_MAX = 69;
    localparam int ROW_STRIDE = (PHASES / 4) * TAPS;

    localparam logic [STEP_W-1:0] STEP_LOW  = STEP_W'(QUARTER);
    localparam logic [STEP_W-1:0] STEP_HIGH = STEP_W'(STEP_Q_MAX * QUARTER);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [POS_W-1:0]           HALF_SPAN  = POS_W'(TAPS / 2) << FRAC_W;

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [COEF_ADDR_W-1:0]     cidx;
        logic signed [COEF_W-1:0]   cval;
    } host_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } native_word_t;

    logic clk = 1'b0;
    logic rst_n;

    pfr_item_if   item_ch();
    pfr_result_if result_ch();
    pfr_cfg_if    cfg_ch();

    polyphase_fir_resampler_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    always #(PERIOD / 2) clk = ~clk;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_left  [RING_DEPTH] = '{default: '0};
    logic signed [SAMPLE_W-1:0] hist_right [RING_DEPTH] = '{default: '0};
    logic signed [COEF_W-1:0]   coef_mem   [COEF_DEPTH];
    logic [COUNT_W-1:0]         host_total   = '0;
    logic [POS_W-1:0]           out_pos      = '0;
    logic [STEP_W-1:0]          step_reg     = STEP_RESET;
    logic                       pass_through = 1'b0;

    host_item_t   host_items [$];
    native_word_t due_outputs [$];
    host_item_t   staged;
    native_word_t want;

    logic item_fire = 1'b0;
    logic cfg_fire  = 1'b0;
    int   mismatches = 0;
    int   src_pause  = 0;
    int   src_quiet  = 0;
    int   sink_pause = 0;
    int   sink_quiet = 0;

    // mostly no pause, some short, a few long, with occasional runs of none at all
    function automatic int pick_pause(inout int quiet);
        int unsigned r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STEP_W-1:0] rand_step(input int q_max);
        return STEP_W'($urandom_range(1, q_max) * QUARTER);
    endfunction

    // an address in one of the coefficient rows that the quarter steps can reach
    function automatic logic [COEF_ADDR_W-1:0] used_addr();
        return COEF_ADDR_W'($urandom_range(0, 3) * ROW_STRIDE + $urandom_range(0, TAPS - 1));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return SAMPLE_MAX;
        if (r == 1)
            return SAMPLE_MIN;
        if (r < 5)
            return SAMPLE_W'($urandom_range(0, 2047) - 1024);
        return SAMPLE_W'($urandom());
    endfunction

    // unused fields carry junk; the block must ignore them
    function automatic host_item_t sample_item(input logic signed [SAMPLE_W-1:0] l,
                                               input logic signed [SAMPLE_W-1:0] r);
        host_item_t it;
        it.opcode = OP_SAMPLE;
        it.left   = l;
        it.right  = r;
        it.cidx   = COEF_ADDR_W'($urandom());
        it.cval   = COEF_W'($urandom());
        return it;
    endfunction

    function automatic host_item_t coef_item(input logic [COEF_ADDR_W-1:0] idx,
                                             input logic signed [COEF_W-1:0] val);
        host_item_t it;
        it.opcode = OP_COEF;
        it.left   = SAMPLE_W'($urandom());
        it.right  = SAMPLE_W'($urandom());
        it.cidx   = idx;
        it.cval   = val;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] round_sat24(input logic signed [63:0] acc);
        logic signed [63:0] q;
        q = (acc + 64'sd32768) >>> 16;
        if (q > 64'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (q < 64'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return q[SAMPLE_W-1:0];
    endfunction

    // FIR over the history ring at one output position
    function automatic native_word_t interpolate_at(input logic [POS_W-1:0] pos);
        logic [COUNT_W-1:0] base;
        logic [COUNT_W-1:0] n;
        logic [63:0]        phase;
        logic [63:0]        ci;
        logic signed [63:0] acc_l;
        logic signed [63:0] acc_r;
        native_word_t       w;
        base  = pos[POS_W-1:FRAC_W];
        phase = (64'(pos[FRAC_W-1:0]) * 64'(PHASES)) >> FRAC_W;
        if (phase > 64'(PHASES - 1))
            phase = 64'(PHASES - 1);
        acc_l = '0;
        acc_r = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            n  = base + COUNT_W'(t) - COUNT_W'(TAPS / 2 - 1);
            ci = (phase * 64'(TAPS) + 64'(t)) % 64'(COEF_DEPTH);
            acc_l += 64'(hist_left[n % RING_DEPTH]) * 64'(coef_mem[ci]);
            acc_r += 64'(hist_right[n % RING_DEPTH]) * 64'(coef_mem[ci]);
        end
        w.left  = round_sat24(acc_l);
        w.right = round_sat24(acc_r);
        w.last  = 1'b0;
        return w;
    endfunction

    // advance the predicted resampler by one accepted item
    task automatic resample_step(input host_item_t it);
        logic [COUNT_W-1:0] idx;
        logic [POS_W-1:0]   limit;
        native_word_t       w;
        bit                 held;
        int                 made;
        if (it.opcode == OP_COEF)
        begin
            coef_mem[it.cidx] = it.cval;
            return;
        end
        idx = host_total;
        hist_left[idx % RING_DEPTH]  = it.left;
        hist_right[idx % RING_DEPTH] = it.right;
        host_total = idx + 1'b1;
        if (pass_through)
        begin
            w.left  = it.left;
            w.right = it.right;
            w.last  = 1'b1;
            due_outputs.push_back(w);
            return;
        end
        limit = {idx, {FRAC_W{1'b0}}};
        held  = 1'b0;
        made  = 0;
        // capped per item; whatever is still due waits for later samples
        while (made < OUT_CAP && out_pos + HALF_SPAN <= limit)
        begin
            if (held)
                due_outputs.push_back(w);
            w = interpolate_at(out_pos);
            held = 1'b1;
            out_pos += POS_W'(step_reg);
            made++;
        end
        if (held)
        begin
            w.last = 1'b1;
            due_outputs.push_back(w);
        end
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (!item_ch.valid || item_fire)
        begin
            if (src_pause > 0)
            begin
                item_ch.valid <= 1'b0;
                src_pause--;
            end
            else if (rst_n && host_items.size() != 0)
            begin
                staged = host_items.pop_front();
                item_ch.valid        <= 1'b1;
                item_ch.opcode       <= staged.opcode;
                item_ch.left_sample  <= staged.left;
                item_ch.right_sample <= staged.right;
                item_ch.coef_index   <= staged.cidx;
                item_ch.coef_value   <= staged.cval;
                src_pause = pick_pause(src_quiet);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (sink_pause > 0)
        begin
            result_ch.ready <= 1'b0;
            sink_pause--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            sink_pause = pick_pause(sink_quiet);
        end
    end

    // monitor: registers and items feed the predictor, result words are checked
    always @(posedge clk)
    begin : watch
        host_item_t seen;
        item_fire <= rst_n && item_ch.valid && item_ch.ready;
        cfg_fire  <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == CFG_STEP_RATIO)
                step_reg = cfg_ch.data;
            else if (cfg_ch.index == CFG_DIRECT_MODE)
                pass_through = cfg_ch.data[0];
        end
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            seen.opcode = item_ch.opcode;
            seen.left   = item_ch.left_sample;
            seen.right  = item_ch.right_sample;
            seen.cidx   = item_ch.coef_index;
            seen.cval   = item_ch.coef_value;
            resample_step(seen);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_outputs.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got L=%0d R=%0d last=%0b",
                         $time, result_ch.out_left, result_ch.out_right, result_ch.last);
                mismatches++;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (result_ch.out_left !== want.left)
                begin
                    $display("%0t: out_left expected %0d got %0d",
                             $time, want.left, result_ch.out_left);
                    mismatches++;
                end
                if (result_ch.out_right !== want.right)
                begin
                    $display("%0t: out_right expected %0d got %0d",
                             $time, want.right, result_ch.out_right);
                    mismatches++;
                end
                if (result_ch.last !== want.last)
                begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, result_ch.last);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_ch.valid <= 1'b0;
    endtask

    // sender holds off until every word is back, then lets the core finish any silent item
    task automatic wait_idle();
        do
            @(posedge clk);
        while (host_items.size() != 0 || item_ch.valid || due_outputs.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic run_phase(input logic [STEP_W-1:0] step, input logic [CFG_DATA_W-1:0] mode,
                             input int count);
        wait_idle();
        write_reg(CFG_STEP_RATIO, step);
        write_reg(CFG_DIRECT_MODE, mode);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                host_items.push_back(coef_item(used_addr(), COEF_W'($urandom())));
            else
                host_items.push_back(sample_item(rand_sample(), rand_sample()));
        end
    endtask

    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.opcode       = OP_SAMPLE;
        item_ch.left_sample  = '0;
        item_ch.right_sample = '0;
        item_ch.coef_index   = '0;
        item_ch.coef_value   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_STEP_RATIO;
        cfg_ch.data          = '0;
        result_ch.ready      = 1'b0;
        rst_n                = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // load the four reachable rows first; the last one gets full-range values
        // so that sums saturate now and then
        for (int r = 0; r < 4; r++)
            for (int t = 0; t < TAPS; t++)
                host_items.push_back(coef_item(COEF_ADDR_W'(r * ROW_STRIDE + t), (r == 3) ?
                                     COEF_W'($urandom()) : COEF_W'($urandom_range(0, 16383) - 8192)));
        wait_idle();

        // pass-through with extreme samples; upper data bits of the mode register are don't-care
        write_reg(CFG_STEP_RATIO, STEP_LOW);
        write_reg(CFG_DIRECT_MODE, {CFG_DATA_W{1'b1}});
        host_items.push_back(sample_item(SAMPLE_MAX, SAMPLE_MIN));
        host_items.push_back(sample_item(SAMPLE_MIN, SAMPLE_MAX));
        host_items.push_back(sample_item('0, '0));
        host_items.push_back(sample_item(-24'sd1, 24'sd1));
        host_items.push_back(sample_item(24'sd1, -24'sd1));
        host_items.push_back(coef_item('0, COEF_MIN));
        host_items.push_back(coef_item({COEF_ADDR_W{1'b1}}, COEF_MAX));
        for (int i = 0; i < 13; i++)
            host_items.push_back(sample_item(rand_sample(), rand_sample()));
        wait_idle();

        // back to interpolation with a long backlog: the per-item cap comes into play
        write_reg(CFG_DIRECT_MODE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
        host_items.push_back(sample_item(SAMPLE_MAX, SAMPLE_MAX));
        host_items.push_back(sample_item(SAMPLE_MIN, SAMPLE_MIN));
        host_items.push_back(sample_item(SAMPLE_MAX, SAMPLE_MIN));
        host_items.push_back(sample_item(SAMPLE_MIN, SAMPLE_MAX));
        host_items.push_back(sample_item('0, '0));

        run_phase(STEP_LOW, '0, 35);
        run_phase(STEP_HIGH, '0, 35);
        run_phase(STEP_RESET, '0, 30);
        run_phase(rand_step(STEP_Q_MAX), '0, 30);
        run_phase(rand_step(STEP_Q_MAX), CFG_DATA_W'(1), 25);
        run_phase(rand_step(8), '0, 35);
        run_phase(rand_step(STEP_Q_MAX), '0, 30);
        wait_idle();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/pfr_pkg.sv
sv/pfr_if.sv
sv/pfr_datapath.sv
sv/pfr_ctrl.sv
sv/polyphase_fir_resampler_core.sv
tb/polyphase_fir_resampler_core_test.sv
